@@ sv/cmfu_pkg.sv @@
// Shared types and constants for the cube map face / texture coordinate block.
// Used by every module of the block but cmfu_queue; depends on nothing else.
`default_nettype none

package cmfu_pkg;

    // Default widths
    localparam int COMPONENT_BITS_DEF      = 16;
    localparam int COORD_FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF         = 2;

    // Cube face codes
    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // Per-item control handed from the classifier to the divider pipeline
    typedef struct packed {
        t_face face;
        logic  flip_u;
        logic  flip_v;
        logic  zero;
    } t_ctrl;

endpackage

`default_nettype wire

@@ sv/cube_map_face_uv.sv @@
// Cube map face selection and face texture coordinates. Top level; depends on
// cmfu_pkg, cmfu_front, cmfu_queue and cmfu_back.
//
// Takes one direction vector per cycle: an item is taken at a clock edge with
// start high and busy low. busy only rises if the small queue between the
// classifier and the divider pipeline fills; the divider pipeline takes the
// queue head every cycle, so this does not happen and a new item can be given
// every cycle. Each result appears on the o_ ports for exactly one cycle with
// o_valid high. The accepting edge writes the queue; the item then passes
// through the registered stages of the divider pipeline and into the output
// register. The receiver cannot stall; results come out in order and must be
// taken when o_valid is high.
`default_nettype none

module cube_map_face_uv #(
    parameter int COMPONENT_BITS      = cmfu_pkg::COMPONENT_BITS_DEF,
    parameter int COORD_FRACTION_BITS = cmfu_pkg::COORD_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH         = cmfu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_x,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_y,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_z,
    output logic                                  o_valid,
    output logic [2:0]                            o_face,
    output logic [COORD_FRACTION_BITS:0]          o_tex_u,
    output logic [COORD_FRACTION_BITS:0]          o_tex_v,
    output logic                                  o_zero_vector
);

    localparam int CB = COMPONENT_BITS;
    localparam int CTW = $bits(cmfu_pkg::t_ctrl);
    localparam int QW = CTW + CB + 2 * (CB + 1);

    cmfu_pkg::t_ctrl f_ctrl;
    logic [CB-1:0]   f_mag;
    logic [CB:0]     f_num_u;
    logic [CB:0]     f_num_v;
    logic            push;
    logic            full;
    logic            empty;
    logic [QW-1:0]   q_in;
    logic [QW-1:0]   q_out;
    cmfu_pkg::t_ctrl b_ctrl;
    logic [CB-1:0]   b_mag;
    logic [CB:0]     b_num_u;
    logic [CB:0]     b_num_v;

    // Classify incoming items
    cmfu_front #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_front (
        .i_start (start),
        .i_full  (full),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_ctrl  (f_ctrl),
        .o_mag   (f_mag),
        .o_num_u (f_num_u),
        .o_num_v (f_num_v),
        .o_push  (push),
        .o_busy  (busy)
    );

    // Hold classified items until the back end takes them
    assign q_in = {f_ctrl, f_mag, f_num_u, f_num_v};

    cmfu_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (!empty),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {b_ctrl, b_mag, b_num_u, b_num_v} = q_out;

    // Divide, saturate, mirror and present results
    cmfu_back #(
        .COMPONENT_BITS     (COMPONENT_BITS),
        .COORD_FRACTION_BITS(COORD_FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!empty),
        .i_ctrl        (b_ctrl),
        .i_mag         (b_mag),
        .i_num_u       (b_num_u),
        .i_num_v       (b_num_v),
        .o_valid       (o_valid),
        .o_face        (o_face),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_zero_vector (o_zero_vector)
    );

endmodule

`default_nettype wire

@@ sv/cmfu_front.sv @@
// Front end: takes a direction item, picks the major axis and face, and forms
// the divisor magnitude and the two coordinate numerators. Uses cmfu_pkg.
`default_nettype none

module cmfu_front #(
    parameter int COMPONENT_BITS = cmfu_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                             i_start,
    input  wire logic                             i_full,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_x,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_y,
    input  wire logic signed [COMPONENT_BITS-1:0] i_dir_z,
    output cmfu_pkg::t_ctrl                       o_ctrl,
    output logic [COMPONENT_BITS-1:0]             o_mag,
    output logic [COMPONENT_BITS:0]               o_num_u,
    output logic [COMPONENT_BITS:0]               o_num_v,
    output logic                                  o_push,
    output logic                                  o_busy
);

    localparam int CB = COMPONENT_BITS;

    logic [CB-1:0]        ax;
    logic [CB-1:0]        ay;
    logic [CB-1:0]        az;
    logic                 x_major;
    logic                 y_major;
    logic                 neg;
    logic signed [CB-1:0] minor_u;
    logic signed [CB-1:0] minor_v;
    logic signed [CB+1:0] su;
    logic signed [CB+1:0] sv;
    logic signed [CB+1:0] nu;
    logic signed [CB+1:0] nv;

    // Accept while the queue has room
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // Magnitudes; the most negative value maps to 2^(CB-1), which still fits
    assign ax = i_dir_x[CB-1] ? (~i_dir_x + CB'(1)) : i_dir_x;
    assign ay = i_dir_y[CB-1] ? (~i_dir_y + CB'(1)) : i_dir_y;
    assign az = i_dir_z[CB-1] ? (~i_dir_z + CB'(1)) : i_dir_z;

    // Major axis, ties to x then y
    assign x_major = (ax >= ay) && (ax >= az);
    assign y_major = !x_major && (ay >= az);

    // Pick face, divisor, minors and mirror flags
    always_comb begin
        o_ctrl.zero = (i_dir_x == '0) && (i_dir_y == '0) && (i_dir_z == '0);
        if (x_major) begin
            neg           = i_dir_x[CB-1];
            o_mag         = ax;
            minor_u       = i_dir_z;
            minor_v       = i_dir_y;
            o_ctrl.flip_u = 1'b1;
            o_ctrl.flip_v = !neg;
            o_ctrl.face   = neg ? cmfu_pkg::FACE_NEG_X : cmfu_pkg::FACE_POS_X;
        end else if (y_major) begin
            neg           = i_dir_y[CB-1];
            o_mag         = ay;
            minor_u       = i_dir_x;
            minor_v       = i_dir_z;
            o_ctrl.flip_u = neg;
            o_ctrl.flip_v = 1'b0;
            o_ctrl.face   = neg ? cmfu_pkg::FACE_NEG_Y : cmfu_pkg::FACE_POS_Y;
        end else begin
            neg           = i_dir_z[CB-1];
            o_mag         = az;
            minor_u       = i_dir_x;
            minor_v       = i_dir_y;
            o_ctrl.flip_u = 1'b0;
            o_ctrl.flip_v = !neg;
            o_ctrl.face   = neg ? cmfu_pkg::FACE_NEG_Z : cmfu_pkg::FACE_POS_Z;
        end
        // Zero vector reports the -x face
        if (o_ctrl.zero) begin
            o_ctrl.face = cmfu_pkg::FACE_NEG_X;
        end
    end

    // Numerators n = s*a + |M|, always in [0, 2|M|]
    assign su = {{2{minor_u[CB-1]}}, minor_u};
    assign sv = {{2{minor_v[CB-1]}}, minor_v};
    assign nu = (neg ? -su : su) + $signed({2'b00, o_mag});
    assign nv = (neg ? -sv : sv) + $signed({2'b00, o_mag});
    assign o_num_u = nu[CB:0];
    assign o_num_v = nv[CB:0];

endmodule

`default_nettype wire

@@ sv/cmfu_queue.sv @@
// Small register queue that decouples the classifier from the divider pipeline.
// Generic payload vector; no package dependencies.
`default_nettype none

module cmfu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW-1:0]    n_rptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Advance pointers with explicit wrap
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/cmfu_back.sv @@
// Back end: pipelined restoring dividers for u and v, one quotient bit per
// stage, then saturation, mirroring and the zero-vector override. Uses cmfu_pkg.
`default_nettype none

module cmfu_back #(
    parameter int COMPONENT_BITS      = cmfu_pkg::COMPONENT_BITS_DEF,
    parameter int COORD_FRACTION_BITS = cmfu_pkg::COORD_FRACTION_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire cmfu_pkg::t_ctrl                i_ctrl,
    input  wire logic [COMPONENT_BITS-1:0]      i_mag,
    input  wire logic [COMPONENT_BITS:0]        i_num_u,
    input  wire logic [COMPONENT_BITS:0]        i_num_v,
    output logic                                o_valid,
    output logic [2:0]                          o_face,
    output logic [COORD_FRACTION_BITS:0]        o_tex_u,
    output logic [COORD_FRACTION_BITS:0]        o_tex_v,
    output logic                                o_zero_vector
);

    localparam int CB = COMPONENT_BITS;
    localparam int F  = COORD_FRACTION_BITS;
    localparam int DW = CB + F + 1;   // dividend width
    localparam int NS = F + 1;        // quotient bits = pipeline stages
    localparam int TW = F + 1;        // coordinate width
    localparam logic [TW-1:0] C_ONE  = TW'(1) << F;
    localparam logic [TW-1:0] C_HALF = TW'(1) << (F - 1);

    logic [DW-1:0]   w_rem_u [NS];
    logic [DW-1:0]   w_rem_v [NS];
    logic [CB:0]     w_div   [NS];
    logic [TW-1:0]   w_q_u   [NS];
    logic [TW-1:0]   w_q_v   [NS];
    cmfu_pkg::t_ctrl w_ctrl  [NS];
    logic            w_valid [NS];

    logic [DW-1:0]   r_rem_u [NS];
    logic [DW-1:0]   r_rem_v [NS];
    logic [CB:0]     r_div   [NS];
    logic [TW-1:0]   r_q_u   [NS];
    logic [TW-1:0]   r_q_v   [NS];
    cmfu_pkg::t_ctrl r_ctrl  [NS];
    logic            r_valid [NS];

    logic [TW-1:0]   t_u;
    logic [TW-1:0]   t_v;
    logic [TW-1:0]   n_tex_u;
    logic [TW-1:0]   n_tex_v;
    logic            r_valid_o;
    logic [2:0]      r_face;
    logic [TW-1:0]   r_tex_u;
    logic [TW-1:0]   r_tex_v;
    logic            r_zero;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [DW-1:0] shifted;
            logic          ge_u;
            logic          ge_v;

            // Stage input: queue head for the first stage, previous stage after
            if (k == 0) begin : g_first
                // Dividend n * 2^F + |M|, divisor 2|M|
                assign w_rem_u[k] = {i_num_u, {F{1'b0}}} + DW'(i_mag);
                assign w_rem_v[k] = {i_num_v, {F{1'b0}}} + DW'(i_mag);
                assign w_div[k]   = {i_mag, 1'b0};
                assign w_q_u[k]   = '0;
                assign w_q_v[k]   = '0;
                assign w_ctrl[k]  = i_ctrl;
                assign w_valid[k] = i_valid;
            end else begin : g_next
                assign w_rem_u[k] = r_rem_u[k-1];
                assign w_rem_v[k] = r_rem_v[k-1];
                assign w_div[k]   = r_div[k-1];
                assign w_q_u[k]   = r_q_u[k-1];
                assign w_q_v[k]   = r_q_v[k-1];
                assign w_ctrl[k]  = r_ctrl[k-1];
                assign w_valid[k] = r_valid[k-1];
            end

            // Try to subtract divisor << (F - k) and set that quotient bit
            assign shifted = DW'(w_div[k]) << (F - k);
            assign ge_u    = (w_rem_u[k] >= shifted);
            assign ge_v    = (w_rem_v[k] >= shifted);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else begin
                    r_valid[k] <= w_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem_u[k] <= ge_u ? (w_rem_u[k] - shifted) : w_rem_u[k];
                r_rem_v[k] <= ge_v ? (w_rem_v[k] - shifted) : w_rem_v[k];
                r_q_u[k]   <= w_q_u[k] | (TW'(ge_u) << (F - k));
                r_q_v[k]   <= w_q_v[k] | (TW'(ge_v) << (F - k));
                r_div[k]   <= w_div[k];
                r_ctrl[k]  <= w_ctrl[k];
            end
        end
    endgenerate

    // Saturate to 1.0, mirror where the face calls for it, override zero vector
    always_comb begin
        t_u = (r_q_u[NS-1] > C_ONE) ? C_ONE : r_q_u[NS-1];
        t_v = (r_q_v[NS-1] > C_ONE) ? C_ONE : r_q_v[NS-1];
        n_tex_u = r_ctrl[NS-1].flip_u ? (C_ONE - t_u) : t_u;
        n_tex_v = r_ctrl[NS-1].flip_v ? (C_ONE - t_v) : t_v;
        if (r_ctrl[NS-1].zero) begin
            n_tex_u = C_HALF;
            n_tex_v = C_HALF;
        end
    end

    // Output register; strobe lasts one cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_o <= 1'b0;
        end else begin
            r_valid_o <= r_valid[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_face  <= r_ctrl[NS-1].face;
        r_tex_u <= n_tex_u;
        r_tex_v <= n_tex_v;
        r_zero  <= r_ctrl[NS-1].zero;
    end

    assign o_valid       = r_valid_o;
    assign o_face        = r_face;
    assign o_tex_u       = r_tex_u;
    assign o_tex_v       = r_tex_v;
    assign o_zero_vector = r_zero;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for cube_map_face_uv: random and directed direction vectors,
// a local face/UV predictor and an in-order result checker.
// Depends on cmfu_pkg and the cube_map_face_uv RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CB        = cmfu_pkg::COMPONENT_BITS_DEF;
    localparam int FB        = cmfu_pkg::COORD_FRACTION_BITS_DEF;
    localparam int LATENCY   = FB + 2;
    localparam int N_RANDOM  = 1500;
    localparam int CYCLE_MAX = 300000;
    localparam int PRINT_MAX = 40;
    localparam logic [FB:0] ONE_Q  = (FB + 1)'(1) << FB;
    localparam logic [FB:0] HALF_Q = (FB + 1)'(1) << (FB - 1);

    // One direction vector, plus a request to wait for the pipeline to drain first
    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        bit                   drain_first;
    } t_dir_item;

    typedef struct {
        cmfu_pkg::t_face face;
        logic [FB:0]     u;
        logic [FB:0]     v;
        logic            zero;
    } t_face_uv;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CB-1:0] i_dir_x;
    logic signed [CB-1:0] i_dir_y;
    logic signed [CB-1:0] i_dir_z;
    logic                 o_valid;
    logic [2:0]           o_face;
    logic [FB:0]          o_tex_u;
    logic [FB:0]          o_tex_v;
    logic                 o_zero_vector;

    t_dir_item dir_q[$];
    t_face_uv  face_uv_q[$];
    int        error_count;
    int        cycle_count;
    int        burst_left;
    int        gap_left;

    cube_map_face_uv #(
        .COMPONENT_BITS      (CB),
        .COORD_FRACTION_BITS (FB)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .o_valid       (o_valid),
        .o_face        (o_face),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_zero_vector (o_zero_vector)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // (minor/major + 1)/2 in Q1.FB, rounded half up, saturated to 1.0
    function automatic logic [FB:0] ratio_to_coord(longint minor, longint major);
        longint mag_major;
        longint num;
        longint q;
        mag_major = (major < 0) ? -major : major;
        num       = ((major < 0) ? -minor : minor) + mag_major;
        if (num < 0)
            num = 0;
        q = ((num <<< FB) + mag_major) / (2 * mag_major);
        if (q > longint'(ONE_Q))
            q = longint'(ONE_Q);
        return q[FB:0];
    endfunction

    function automatic logic [FB:0] mirror(logic [FB:0] c);
        return ONE_Q - c;
    endfunction

    // Pick the face of the largest component (ties to x, then y) and its UV
    function automatic t_face_uv predict_face_uv(t_dir_item d);
        t_face_uv r;
        longint   x;
        longint   y;
        longint   z;
        longint   ax;
        longint   ay;
        longint   az;
        x  = d.x;
        y  = d.y;
        z  = d.z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r.zero = 1'b0;
        if (x == 0 && y == 0 && z == 0) begin
            r.face = cmfu_pkg::FACE_NEG_X;
            r.u    = HALF_Q;
            r.v    = HALF_Q;
            r.zero = 1'b1;
        end else if (ax >= ay && ax >= az) begin
            r.u = mirror(ratio_to_coord(z, x));
            if (x > 0) begin
                r.face = cmfu_pkg::FACE_POS_X;
                r.v    = mirror(ratio_to_coord(y, x));
            end else begin
                r.face = cmfu_pkg::FACE_NEG_X;
                r.v    = ratio_to_coord(y, x);
            end
        end else if (ay >= az) begin
            r.v = ratio_to_coord(z, y);
            if (y > 0) begin
                r.face = cmfu_pkg::FACE_POS_Y;
                r.u    = ratio_to_coord(x, y);
            end else begin
                r.face = cmfu_pkg::FACE_NEG_Y;
                r.u    = mirror(ratio_to_coord(x, y));
            end
        end else begin
            r.u = ratio_to_coord(x, z);
            if (z > 0) begin
                r.face = cmfu_pkg::FACE_POS_Z;
                r.v    = mirror(ratio_to_coord(y, z));
            end else begin
                r.face = cmfu_pkg::FACE_NEG_Z;
                r.v    = ratio_to_coord(y, z);
            end
        end
        return r;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic add_item(int x, int y, int z, bit drain_first);
        t_dir_item d;
        d.x           = CB'(x);
        d.y           = CB'(y);
        d.z           = CB'(z);
        d.drain_first = drain_first;
        dir_q.push_back(d);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        error_count++;
        if (error_count <= PRINT_MAX)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // Driver: launch items in bursts, record the expected result on acceptance
    always @(posedge i_clk) begin
        t_dir_item d;
        bit        accepted;
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_dir_x    <= '0;
            i_dir_y    <= '0;
            i_dir_z    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                d.x = i_dir_x;
                d.y = i_dir_y;
                d.z = i_dir_z;
                face_uv_q.push_back(predict_face_uv(d));
            end
            if (start && busy) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (dir_q.size() == 0
                         || (dir_q[0].drain_first && face_uv_q.size() != 0)) begin
                start <= 1'b0;
            end else begin
                d = dir_q.pop_front();
                start   <= 1'b1;
                i_dir_x <= d.x;
                i_dir_y <= d.y;
                i_dir_z <= d.z;
                if (burst_left <= 1) begin
                    burst_left = rand_between(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : rand_between(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_face_uv want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (face_uv_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = face_uv_q.pop_front();
                if (o_face !== want.face)
                    report_mismatch("face", o_face, want.face);
                if (o_tex_u !== want.u)
                    report_mismatch("tex_u", o_tex_u, want.u);
                if (o_tex_v !== want.v)
                    report_mismatch("tex_v", o_tex_v, want.v);
                if (o_zero_vector !== want.zero)
                    report_mismatch("zero_vector", o_zero_vector, want.zero);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_MAX) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int comp[3];
        int kind;
        int mag_major;
        int rot;
        error_count = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;

        // Directed: zero vector, each face at full scale, most negative value, ties
        add_item(0, 0, 0, 0);
        add_item(32767, 0, 0, 0);
        add_item(-32768, 0, 0, 0);
        add_item(0, 32767, 0, 0);
        add_item(0, -32768, 0, 0);
        add_item(0, 0, 32767, 0);
        add_item(0, 0, -32768, 0);
        add_item(100, 100, 100, 0);
        add_item(-100, 100, 50, 0);
        add_item(0, 200, -200, 0);
        add_item(5, -7, 7, 0);
        add_item(-32768, -32768, -32768, 0);
        add_item(32767, -32768, 32767, 0);
        add_item(32767, 32767, 32767, 0);
        add_item(-32768, 32767, -32767, 0);
        add_item(-32767, -32767, 32767, 0);
        add_item(1, 0, 0, 0);
        add_item(0, 0, -1, 0);
        add_item(1, 1, -1, 0);
        add_item(-1, -1, -1, 0);
        add_item(3, -1, 1, 0);
        add_item(-32768, 32767, 32767, 0);
        add_item(2, 0, 1, 0);
        add_item(0, -3, 2, 0);

        // Random: mostly full range, with small values, forced ties and scaled minors
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    foreach (comp[k]) comp[k] = $urandom_range(0, 65535);
                end
                4: begin
                    foreach (comp[k]) comp[k] = rand_between(-3, 3);
                end
                5, 6: begin
                    mag_major = rand_between(1, 32768);
                    comp[0] = $urandom_range(0, 1) ? mag_major : -mag_major;
                    comp[1] = $urandom_range(0, 1) ? mag_major : -mag_major;
                    comp[2] = rand_between(-(mag_major - 1), mag_major - 1);
                end
                7: begin
                    comp[0] = $urandom_range(0, 1) ? 32767 : -32768;
                    comp[1] = $urandom_range(0, 65535);
                    comp[2] = $urandom_range(0, 65535);
                end
                default: begin
                    mag_major = rand_between(1, 32767);
                    comp[0] = $urandom_range(0, 1) ? mag_major : -mag_major;
                    comp[1] = rand_between(-mag_major, mag_major);
                    comp[2] = rand_between(-mag_major, mag_major);
                end
            endcase
            // rotate so the forced major lands on any axis
            rot = (kind >= 5) ? $urandom_range(0, 2) : 0;
            add_item(comp[rot], comp[(rot + 1) % 3], comp[(rot + 2) % 3],
                     i == 0 || i == 500 || i == 1000);
        end

        // Reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all items taken, all results back, then let the pipeline settle
        do
            @(posedge i_clk);
        while (dir_q.size() != 0 || start || face_uv_q.size() != 0);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
